FILE: sv/csrspmv_pkg.sv
// Shared types and constants of the CSR sparse matrix-vector multiply block.
package csrspmv_pkg;

	localparam int COL_W = 10;
	localparam int VAL_W = 32;
	localparam int ROW_W = 16;
	localparam int SUM_W = 64;
	localparam int RCNT_W = 17;

	localparam int OFIFO_DEPTH = 4;
	localparam int OFIFO_AW = 2;
	localparam int OFIFO_CW = 3;

	localparam logic [RCNT_W-1:0] ROW_LIMIT_HW = 17'd65536;
	localparam logic [RCNT_W-1:0] ROW_LIMIT_MIN = 17'd1;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_NONZERO = 2'd1,
		MODE_EMPTY   = 2'd2,
		MODE_UNUSED  = 2'd3
	} mode_t;

	typedef struct packed {
		logic  valid;
		mode_t mode;
		logic  last;
	} stage_ctl_t;

	typedef struct packed {
		logic [ROW_W-1:0]        row_index;
		logic signed [SUM_W-1:0] row_sum;
		logic                    saturated;
	} result_t;

endpackage

FILE: sv/csr_sparse_matrix_vector_multiply.sv
// Top level of the CSR sparse matrix-vector multiply block.
// The block accepts one word per clock while in_stall is low and computes
// y = A*x in Q16.16 with a saturating Q32.32 row sum. A load word (mode 0)
// writes x[column_index], a nonzero word (mode 1) adds value*x[column] into
// the open row and closes it when row_last is set, and an empty-row word
// (mode 2) emits a zero sum. A closed row passes the first stage register, the
// multiply stage register and the output queue before it reaches the output.
// Each word passes through the vector store read, one 32x32 multiply and one
// 64-bit saturating add, so a new word enters every cycle while in_stall is
// low. Results wait in a four-entry queue; in_stall rises only while that
// queue plus the two words in flight would fill it. Load x before using it.
module csr_sparse_matrix_vector_multiply #(
	parameter int VECTOR_DEPTH = 1024,
	parameter int MAX_ROWS = 65536
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [1:0]                              mode,
	input  logic [csrspmv_pkg::COL_W-1:0]           column_index,
	input  logic signed [csrspmv_pkg::VAL_W-1:0]    operand_value,
	input  logic                                    row_last,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [csrspmv_pkg::ROW_W-1:0]           row_index,
	output logic signed [csrspmv_pkg::SUM_W-1:0]    row_sum,
	output logic                                    saturated,
	input  logic                                    row_count_we,
	input  logic [csrspmv_pkg::RCNT_W-1:0]          row_count_wdata
);

	csrspmv_pkg::stage_ctl_t ctl_s1;
	logic signed [csrspmv_pkg::VAL_W-1:0] val_s1;
	logic signed [csrspmv_pkg::VAL_W-1:0] elem_s1;
	logic                                 valid_s2;
	logic                                 push;
	csrspmv_pkg::result_t                 push_data;
	csrspmv_pkg::result_t                 head;
	logic [csrspmv_pkg::OFIFO_CW-1:0]     count;
	logic [csrspmv_pkg::OFIFO_CW-1:0]     occupancy;
	logic                                 accept;
	logic                                 pop;

	assign occupancy = count + csrspmv_pkg::OFIFO_CW'(ctl_s1.valid) +
		csrspmv_pkg::OFIFO_CW'(valid_s2);
	assign in_stall  = (occupancy >= csrspmv_pkg::OFIFO_CW'(csrspmv_pkg::OFIFO_DEPTH));
	assign accept    = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	csrspmv_vec_store #(
		.VECTOR_DEPTH(VECTOR_DEPTH)
	) u_vec_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.mode         (csrspmv_pkg::mode_t'(mode)),
		.column_index (column_index),
		.operand_value(operand_value),
		.row_last     (row_last),
		.ctl_s1       (ctl_s1),
		.val_s1       (val_s1),
		.elem_s1      (elem_s1)
	);

	csrspmv_mac #(
		.MAX_ROWS(MAX_ROWS)
	) u_mac (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl_s1         (ctl_s1),
		.val_s1         (val_s1),
		.elem_s1        (elem_s1),
		.row_count_we   (row_count_we),
		.row_count_wdata(row_count_wdata),
		.valid_s2       (valid_s2),
		.push           (push),
		.push_data      (push_data)
	);

	csrspmv_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.not_empty(out_valid),
		.head     (head),
		.count    (count)
	);

	assign row_index = head.row_index;
	assign row_sum   = head.row_sum;
	assign saturated = head.saturated;

endmodule

FILE: sv/csrspmv_vec_store.sv
// Vector store with address folding and the first pipeline stage.
module csrspmv_vec_store #(
	parameter int VECTOR_DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    accept,
	input  csrspmv_pkg::mode_t                      mode,
	input  logic [csrspmv_pkg::COL_W-1:0]           column_index,
	input  logic signed [csrspmv_pkg::VAL_W-1:0]    operand_value,
	input  logic                                    row_last,
	output csrspmv_pkg::stage_ctl_t                 ctl_s1,
	output logic signed [csrspmv_pkg::VAL_W-1:0]    val_s1,
	output logic signed [csrspmv_pkg::VAL_W-1:0]    elem_s1
);

	localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
	localparam int CW = csrspmv_pkg::COL_W;

	logic [AW-1:0] addr;
	logic [csrspmv_pkg::VAL_W-1:0] mem [VECTOR_DEPTH];

	generate
		if (VECTOR_DEPTH >= (1 << CW)) begin : g_direct
			assign addr = AW'(column_index);
		end else begin : g_fold
			localparam int FRAC_W = 2 * CW;
			localparam int unsigned RECIP = (1 << FRAC_W) / VECTOR_DEPTH;
			localparam logic [CW-1:0] DEPTH_C = CW'(VECTOR_DEPTH);

			logic [CW+FRAC_W-1:0] scaled;
			logic [CW-1:0]        quot;
			logic [2*CW-1:0]      back;
			logic [CW-1:0]        rem0;
			logic [CW-1:0]        rem1;

			// The reciprocal estimate is low by at most one, so one correction suffices.
			assign scaled = (CW+FRAC_W)'(column_index) * (CW+FRAC_W)'(RECIP);
			assign quot   = scaled[CW+FRAC_W-1:FRAC_W];
			assign back   = quot * DEPTH_C;
			assign rem0   = column_index - back[CW-1:0];
			assign rem1   = (rem0 >= DEPTH_C) ? (rem0 - DEPTH_C) : rem0;
			assign addr   = AW'(rem1);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (accept) begin
			if (mode == csrspmv_pkg::MODE_LOAD) begin
				mem[addr] <= operand_value;
			end
			elem_s1 <= mem[addr];
			val_s1  <= operand_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.mode  <= mode;
			ctl_s1.last  <= row_last;
		end
	end

endmodule

FILE: sv/csrspmv_mac.sv
// Multiply stage, saturating row accumulator and row counter.
module csrspmv_mac #(
	parameter int MAX_ROWS = 65536
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  csrspmv_pkg::stage_ctl_t                 ctl_s1,
	input  logic signed [csrspmv_pkg::VAL_W-1:0]    val_s1,
	input  logic signed [csrspmv_pkg::VAL_W-1:0]    elem_s1,
	input  logic                                    row_count_we,
	input  logic [csrspmv_pkg::RCNT_W-1:0]          row_count_wdata,
	output logic                                    valid_s2,
	output logic                                    push,
	output csrspmv_pkg::result_t                    push_data
);

	localparam logic [csrspmv_pkg::RCNT_W-1:0] ROW_CAP =
		(MAX_ROWS < 65536) ? csrspmv_pkg::RCNT_W'(MAX_ROWS) : csrspmv_pkg::ROW_LIMIT_HW;

	csrspmv_pkg::stage_ctl_t ctl_s2;
	logic signed [csrspmv_pkg::SUM_W-1:0] prod_s2;

	logic signed [csrspmv_pkg::SUM_W-1:0] acc_q;
	logic                                 clipped_q;
	logic [csrspmv_pkg::ROW_W-1:0]        cur_row_q;
	logic [csrspmv_pkg::RCNT_W-1:0]       row_count_q;

	logic [csrspmv_pkg::RCNT_W-1:0]       row_limit;
	logic [csrspmv_pkg::RCNT_W-1:0]       row_next;
	logic [csrspmv_pkg::ROW_W-1:0]        row_wrap;
	logic signed [csrspmv_pkg::SUM_W-1:0] sum_raw;
	logic signed [csrspmv_pkg::SUM_W-1:0] sum_sat;
	logic                                 ovf;
	logic                                 clip_next;
	logic                                 close_row;
	logic                                 empty_row;
	logic                                 add_only;

	always_ff @(posedge clk) begin
		prod_s2 <= val_s1 * elem_s1;
	end

	always_comb begin
		if (row_count_q == '0) begin
			row_limit = csrspmv_pkg::ROW_LIMIT_MIN;
		end else if (row_count_q > ROW_CAP) begin
			row_limit = ROW_CAP;
		end else begin
			row_limit = row_count_q;
		end
		row_next = {1'b0, cur_row_q} + csrspmv_pkg::RCNT_W'(1);
		row_wrap = (row_next >= row_limit) ? '0 : row_next[csrspmv_pkg::ROW_W-1:0];

		sum_raw = acc_q + prod_s2;
		ovf = (acc_q[csrspmv_pkg::SUM_W-1] == prod_s2[csrspmv_pkg::SUM_W-1]) &&
			(sum_raw[csrspmv_pkg::SUM_W-1] != acc_q[csrspmv_pkg::SUM_W-1]);
		if (ovf) begin
			sum_sat = acc_q[csrspmv_pkg::SUM_W-1] ? csrspmv_pkg::SUM_MIN : csrspmv_pkg::SUM_MAX;
		end else begin
			sum_sat = sum_raw;
		end
		clip_next = clipped_q | ovf;

		add_only  = ctl_s2.valid && (ctl_s2.mode == csrspmv_pkg::MODE_NONZERO) && !ctl_s2.last;
		close_row = ctl_s2.valid && (ctl_s2.mode == csrspmv_pkg::MODE_NONZERO) && ctl_s2.last;
		empty_row = ctl_s2.valid && (ctl_s2.mode == csrspmv_pkg::MODE_EMPTY);

		push = close_row || empty_row;
		push_data.row_index = cur_row_q;
		push_data.row_sum   = close_row ? sum_sat : '0;
		push_data.saturated = close_row && clip_next;
	end

	assign valid_s2 = ctl_s2.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2      <= '0;
			acc_q       <= '0;
			clipped_q   <= 1'b0;
			cur_row_q   <= '0;
			row_count_q <= csrspmv_pkg::ROW_LIMIT_MIN;
		end else begin
			ctl_s2 <= ctl_s1;
			if (row_count_we) begin
				row_count_q <= row_count_wdata;
			end
			if (add_only) begin
				acc_q     <= sum_sat;
				clipped_q <= clip_next;
			end else if (push) begin
				acc_q     <= '0;
				clipped_q <= 1'b0;
				cur_row_q <= row_wrap;
			end
		end
	end

endmodule

FILE: sv/csrspmv_out_fifo.sv
// Small result queue that decouples the pipeline from the output stall.
module csrspmv_out_fifo (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	input  csrspmv_pkg::result_t                 push_data,
	input  logic                                 pop,
	output logic                                 not_empty,
	output csrspmv_pkg::result_t                 head,
	output logic [csrspmv_pkg::OFIFO_CW-1:0]     count
);

	csrspmv_pkg::result_t entries [csrspmv_pkg::OFIFO_DEPTH];

	logic [csrspmv_pkg::OFIFO_AW-1:0] wr_ptr_q;
	logic [csrspmv_pkg::OFIFO_AW-1:0] rd_ptr_q;
	logic [csrspmv_pkg::OFIFO_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + csrspmv_pkg::OFIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + csrspmv_pkg::OFIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + csrspmv_pkg::OFIFO_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - csrspmv_pkg::OFIFO_CW'(1);
			end
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = entries[rd_ptr_q];
	assign count     = count_q;

endmodule

FILE: sv/csrspmv_checker.sv
// Port-level checks for the CSR sparse matrix-vector multiply block, with bind.
module csrspmv_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [csrspmv_pkg::ROW_W-1:0]        row_index,
	input logic signed [csrspmv_pkg::SUM_W-1:0] row_sum,
	input logic                                 saturated
);

	// A result that appears on an empty output was accepted earlier at the input.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 3))
		else $error("result appeared without a matching accepted word");

	// With nothing waiting at the output the input side is never held off.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while the output queue is empty");

	// A stalled result keeps its word until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row_index) &&
			$stable(row_sum) && $stable(saturated))
		else $error("stalled result word changed");

endmodule

bind csr_sparse_matrix_vector_multiply csrspmv_checker u_csrspmv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.row_index (row_index),
	.row_sum   (row_sum),
	.saturated (saturated)
);

FILE: sim/csr_sparse_matrix_vector_multiply_test.sv
// Self-checking testbench for the CSR sparse matrix-vector multiply block.
module csr_sparse_matrix_vector_multiply_test;

	localparam int VEC_DEPTH = 1024;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_WORDS = 255;
	localparam int QUIET_CYCLES = 8;

	typedef struct packed {
		csrspmv_pkg::mode_t               m;
		logic [csrspmv_pkg::COL_W-1:0]    c;
		logic [csrspmv_pkg::VAL_W-1:0]    v;
		logic                             l;
		logic                             typed;
		csrspmv_pkg::result_t             res;
	} plan_word_t;

	logic                                 clk;
	logic                                 arst_n = 1'b0;
	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	logic [1:0]                           mode = csrspmv_pkg::MODE_LOAD;
	logic [csrspmv_pkg::COL_W-1:0]        column_index = '0;
	logic signed [csrspmv_pkg::VAL_W-1:0] operand_value = '0;
	logic                                 row_last = 1'b0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic [csrspmv_pkg::ROW_W-1:0]        row_index;
	logic signed [csrspmv_pkg::SUM_W-1:0] row_sum;
	logic                                 saturated;
	logic                                 row_count_we = 1'b0;
	logic [csrspmv_pkg::RCNT_W-1:0]       row_count_wdata = '0;

	logic [csrspmv_pkg::VAL_W-1:0]        xstore [VEC_DEPTH];
	logic signed [csrspmv_pkg::SUM_W-1:0] acc = '0;
	logic                                 clip_seen = 1'b0;
	int unsigned                          cur_row = 0;
	logic [csrspmv_pkg::RCNT_W-1:0]       row_cnt = csrspmv_pkg::ROW_LIMIT_MIN;

	bit                                   written [VEC_DEPTH];
	logic [csrspmv_pkg::COL_W-1:0]        loaded_cols [$];
	csrspmv_pkg::result_t                 sums_due [$];
	plan_word_t                           plan [$];
	csrspmv_pkg::result_t                 due;
	int                                   errors = 0;
	int                                   words_sent = 0;
	int                                   cycle_count = 0;
	int                                   stall_hold = 0;
	int                                   stall_pick;
	bit                                   calm = 1'b0;

	csr_sparse_matrix_vector_multiply uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.column_index(column_index),
		.operand_value(operand_value),
		.row_last(row_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.row_index(row_index),
		.row_sum(row_sum),
		.saturated(saturated),
		.row_count_we(row_count_we),
		.row_count_wdata(row_count_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("csr_sparse_matrix_vector_multiply regression: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (stall_hold > 0) begin
			stall_hold--;
		end else if (calm) begin
			out_stall <= 1'b0;
		end else begin
			stall_pick = $urandom_range(0, 9);
			out_stall <= (stall_pick >= 6);
			stall_hold = (stall_pick == 9) ? $urandom_range(8, 30) : $urandom_range(0, 4);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (sums_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected row word: row %0d sum %h saturated %0d",
						row_index, row_sum, saturated);
			end else begin
				due = sums_due.pop_front();
				if (row_index !== due.row_index || row_sum !== due.row_sum ||
						saturated !== due.saturated) begin
					errors++;
					if (errors <= 10)
						$display({"row word mismatch: expected row %0d sum %h sat %0d,",
							" got row %0d sum %h sat %0d"},
							due.row_index, due.row_sum, due.saturated,
							row_index, row_sum, saturated);
				end
			end
		end
	end

	// Updates the vector store, the running row sum and the row counter for one
	// accepted word, and returns 1 with the row word when the word closes a row.
	function automatic bit spmv_predict(input csrspmv_pkg::mode_t m,
			input logic [csrspmv_pkg::COL_W-1:0] c,
			input logic [csrspmv_pkg::VAL_W-1:0] v, input logic l,
			output csrspmv_pkg::result_t r);
		logic signed [csrspmv_pkg::SUM_W-1:0] a, b, prod, total;
		int unsigned limit;
		r = '0;
		case (m)
			csrspmv_pkg::MODE_LOAD: begin
				xstore[c] = v;
				return 1'b0;
			end
			csrspmv_pkg::MODE_NONZERO: begin
				a = $signed(v);
				b = $signed(xstore[c]);
				prod = a * b;
				total = acc + prod;
				if (acc[csrspmv_pkg::SUM_W-1] == prod[csrspmv_pkg::SUM_W-1] &&
						total[csrspmv_pkg::SUM_W-1] != acc[csrspmv_pkg::SUM_W-1]) begin
					total = acc[csrspmv_pkg::SUM_W-1] ? csrspmv_pkg::SUM_MIN :
						csrspmv_pkg::SUM_MAX;
					clip_seen = 1'b1;
				end
				acc = total;
				if (!l)
					return 1'b0;
				r = {cur_row[csrspmv_pkg::ROW_W-1:0], acc, clip_seen};
			end
			csrspmv_pkg::MODE_EMPTY: begin
				r = {cur_row[csrspmv_pkg::ROW_W-1:0], {csrspmv_pkg::SUM_W{1'b0}}, 1'b0};
			end
			default: begin
				return 1'b0;
			end
		endcase
		acc = '0;
		clip_seen = 1'b0;
		limit = (row_cnt == 0) ? 1 : (row_cnt > csrspmv_pkg::ROW_LIMIT_HW) ?
			csrspmv_pkg::ROW_LIMIT_HW : row_cnt;
		cur_row = (cur_row + 1 >= limit) ? 0 : cur_row + 1;
		return 1'b1;
	endfunction

	function automatic void plan_word(input csrspmv_pkg::mode_t m,
			input logic [csrspmv_pkg::COL_W-1:0] c,
			input logic [csrspmv_pkg::VAL_W-1:0] v, input logic l);
		plan.insert(plan.size(), {m, c, v, l, 1'b0,
			{(csrspmv_pkg::ROW_W + csrspmv_pkg::SUM_W + 1){1'b0}}});
	endfunction

	function automatic void plan_row(input csrspmv_pkg::mode_t m,
			input logic [csrspmv_pkg::COL_W-1:0] c,
			input logic [csrspmv_pkg::VAL_W-1:0] v, input logic l,
			input logic [csrspmv_pkg::SUM_W-1:0] s, input logic sat);
		plan.insert(plan.size(), {m, c, v, l, 1'b1, {csrspmv_pkg::ROW_W{1'b0}}, s, sat});
	endfunction

	function automatic int pick_gap();
		int p;
		if (calm)
			return 0;
		p = $urandom_range(0, 9);
		if (p < 6)
			return 0;
		if (p < 9)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic logic [csrspmv_pkg::VAL_W-1:0] pick_value();
		logic [csrspmv_pkg::VAL_W-1:0] r;
		r = $urandom;
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3, 4: return r;
			default: return {{12{r[19]}}, r[19:0]};
		endcase
	endfunction

	function automatic logic [csrspmv_pkg::COL_W-1:0] pick_col();
		return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
	endfunction

	function automatic logic [csrspmv_pkg::COL_W-1:0] pick_any_col();
		return csrspmv_pkg::COL_W'($urandom_range(0, VEC_DEPTH - 1));
	endfunction

	task automatic push_word(input csrspmv_pkg::mode_t m,
			input logic [csrspmv_pkg::COL_W-1:0] c,
			input logic [csrspmv_pkg::VAL_W-1:0] v, input logic l,
			input logic typed = 1'b0, input csrspmv_pkg::result_t typed_res = '0);
		int gap;
		csrspmv_pkg::result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			operand_value <= $urandom;
			row_last <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		column_index <= c;
		operand_value <= v;
		row_last <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (spmv_predict(m, c, v, l, r))
			sums_due.insert(sums_due.size(), typed ? typed_res : r);
		if (m == csrspmv_pkg::MODE_LOAD && !written[c]) begin
			written[c] = 1'b1;
			loaded_cols.insert(loaded_cols.size(), c);
		end
		if (m != csrspmv_pkg::MODE_UNUSED)
			words_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sums_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_row_count(input logic [csrspmv_pkg::RCNT_W-1:0] n);
		drain_results();
		repeat (QUIET_CYCLES) @(negedge clk);
		row_count_we <= 1'b1;
		row_count_wdata <= n;
		@(negedge clk);
		row_count_we <= 1'b0;
		row_cnt = n;
	endtask

	// Mostly complete rows with random content; the rest are empty rows, rows
	// cut short by an empty-row word, bare loads and unused-mode words.
	task automatic send_row();
		int pick, k;
		pick = $urandom_range(0, 99);
		if (pick < 2)
			drain_results();
		if (pick < 12) begin
			push_word(csrspmv_pkg::MODE_EMPTY, pick_col(), pick_value(), 1'($urandom));
		end else if (pick < 17) begin
			push_word(csrspmv_pkg::MODE_UNUSED, pick_col(), pick_value(), 1'($urandom));
		end else if (pick < 27) begin
			k = $urandom_range(1, 3);
			repeat (k) push_word(csrspmv_pkg::MODE_NONZERO, pick_col(), pick_value(), 1'b0);
			push_word(csrspmv_pkg::MODE_EMPTY, pick_col(), pick_value(), 1'($urandom));
		end else if (pick < 35) begin
			k = $urandom_range(1, 4);
			repeat (k) push_word(csrspmv_pkg::MODE_LOAD, pick_any_col(), pick_value(),
				1'($urandom));
		end else begin
			k = (pick < 40) ? $urandom_range(7, 24) : $urandom_range(1, 6);
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(0, 99) < 15)
					push_word(csrspmv_pkg::MODE_LOAD, pick_any_col(), pick_value(),
						1'($urandom));
				push_word(csrspmv_pkg::MODE_NONZERO, pick_col(), pick_value(), i == k - 1);
			end
		end
	endtask

	initial begin
		logic [csrspmv_pkg::RCNT_W-1:0] row_counts [6];
		row_counts = '{csrspmv_pkg::ROW_LIMIT_HW, 17'd0, 17'h1FFFF, 17'd2, 17'd3, 17'd0};
		row_counts[5] = csrspmv_pkg::RCNT_W'($urandom_range(4, 40));

		// With the reset row count of one every row word carries row zero.
		plan_row(csrspmv_pkg::MODE_EMPTY, 10'd0, 32'h0, 1'b1, 64'h0, 1'b0);
		plan_word(csrspmv_pkg::MODE_LOAD, 10'd0, 32'h7FFF_FFFF, 1'b0);
		plan_word(csrspmv_pkg::MODE_LOAD, 10'd1023, 32'h8000_0000, 1'b1);
		plan_word(csrspmv_pkg::MODE_LOAD, 10'd1, 32'h0001_0000, 1'b0);
		plan_row(csrspmv_pkg::MODE_NONZERO, 10'd1, 32'h0001_0000, 1'b1,
			64'h0000_0001_0000_0000, 1'b0);
		plan_row(csrspmv_pkg::MODE_NONZERO, 10'd1023, 32'h8000_0000, 1'b1,
			64'h4000_0000_0000_0000, 1'b0);
		// The sum clips at the positive bound and then at the negative bound.
		plan_word(csrspmv_pkg::MODE_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
		plan_word(csrspmv_pkg::MODE_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
		plan_row(csrspmv_pkg::MODE_NONZERO, 10'd1023, 32'h8000_0000, 1'b1,
			csrspmv_pkg::SUM_MAX, 1'b1);
		plan_word(csrspmv_pkg::MODE_NONZERO, 10'd1023, 32'h7FFF_FFFF, 1'b0);
		plan_word(csrspmv_pkg::MODE_NONZERO, 10'd1023, 32'h7FFF_FFFF, 1'b0);
		plan_row(csrspmv_pkg::MODE_NONZERO, 10'd1023, 32'h7FFF_FFFF, 1'b1,
			csrspmv_pkg::SUM_MIN, 1'b1);
		// An empty row in the middle of a clipped row drops the sum and the flag.
		plan_word(csrspmv_pkg::MODE_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
		plan_word(csrspmv_pkg::MODE_NONZERO, 10'd1023, 32'h8000_0000, 1'b0);
		plan_row(csrspmv_pkg::MODE_EMPTY, 10'd1023, 32'hFFFF_FFFF, 1'b0, 64'h0, 1'b0);
		plan_row(csrspmv_pkg::MODE_NONZERO, 10'd1, 32'h0001_0000, 1'b1,
			64'h0000_0001_0000_0000, 1'b0);
		plan_word(csrspmv_pkg::MODE_UNUSED, 10'd0, 32'h1234_5678, 1'b1);
		plan_row(csrspmv_pkg::MODE_NONZERO, 10'd0, 32'h7FFF_FFFF, 1'b1,
			64'h3FFF_FFFF_0000_0001, 1'b0);
		// A load inside an open row leaves the running sum alone.
		plan_word(csrspmv_pkg::MODE_NONZERO, 10'd1, 32'h0001_0000, 1'b0);
		plan_word(csrspmv_pkg::MODE_LOAD, 10'd2, 32'h0002_0000, 1'b1);
		plan_row(csrspmv_pkg::MODE_NONZERO, 10'd2, 32'h0001_0000, 1'b1,
			64'h0000_0003_0000_0000, 1'b0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			push_word(plan[i].m, plan[i].c, plan[i].v, plan[i].l, plan[i].typed, plan[i].res);

		for (int p = 0; p < 6; p++) begin
			set_row_count(row_counts[p]);
			calm = (p == 2) || ($urandom_range(0, 3) == 0);
			words_sent = 0;
			while (words_sent < PHASE_WORDS)
				send_row();
			calm = 1'b0;
		end

		drain_results();
		repeat (4 * QUIET_CYCLES) @(negedge clk);
		if (errors == 0 && sums_due.size() == 0)
			$display("csr_sparse_matrix_vector_multiply regression: pass");
		else
			$display("csr_sparse_matrix_vector_multiply regression: fail");
		$finish;
	end

endmodule
